// ----- rtl/core/ptla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptla_pkg: shared types, constants and helpers for the look-at block
// widths of the point, angle and cordic datapaths, csr map, arctangent table
// ----------------------------------------------------------------------------
package ptla_pkg;

   // coordinate and arithmetic widths
   localparam int CoordW   = 24;   // signed q7.16 metres
   localparam int DiffW    = 25;   // difference of two coordinates
   localparam int ProdW    = 50;   // square of a difference
   localparam int AccW     = 51;   // sum of three squares
   localparam int ThrW     = 23;   // deadband threshold
   localparam int SqInW    = 64;   // radicand of the square root
   localparam int SqRemW   = 36;   // partial remainder
   localparam int SqRootW  = 32;   // root
   localparam int CordW    = 51;   // cordic x and y
   localparam int AngW     = 28;   // angle in 2^-24 rad
   localparam int AngOutW  = 16;   // q2.13 radians
   localparam int CntW     = 5;    // step counter
   localparam int PreShift = 23;   // scaling of the vector before a pass
   localparam int HypShift = 16;   // scaling of the hypot before the tilt pass
   localparam int SqShift  = 14;   // hypot radicand scaling
   localparam int OutShift = 11;   // 2^-24 rad down to 2^-13 rad

   localparam int CordicStepsDef = 16;
   localparam int AtanLen        = 24;

   localparam logic signed [AngW-1:0] PiFine    = AngW'(52707179);
   localparam logic signed [AngW:0]   RoundBias = (AngW+1)'(1024);

   // csr map
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 23;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DEADBAND = 3'd0,
      CSR_PAN_MIN  = 3'd1,
      CSR_PAN_MAX  = 3'd2,
      CSR_TILT_MIN = 3'd3,
      CSR_TILT_MAX = 3'd4
   } csr_index_type;

   localparam logic [ThrW-1:0]           DeadbandRst = ThrW'(655);
   localparam logic signed [AngOutW-1:0] PanMinRst   = -16'sd12861;
   localparam logic signed [AngOutW-1:0] PanMaxRst   = 16'sd20070;
   localparam logic signed [AngOutW-1:0] TiltMinRst  = -16'sd10813;
   localparam logic signed [AngOutW-1:0] TiltMaxRst  = 16'sd6472;

   // atan(2^-i) in 2^-24 rad
   function automatic logic signed [AngW-1:0] atan_fine(input logic [CntW-1:0] idx);
      logic signed [AngW-1:0] v;
      case (idx)
         5'd0:    v = AngW'(13176795);
         5'd1:    v = AngW'(7778716);
         5'd2:    v = AngW'(4110060);
         5'd3:    v = AngW'(2086331);
         5'd4:    v = AngW'(1047214);
         5'd5:    v = AngW'(524117);
         5'd6:    v = AngW'(262123);
         5'd7:    v = AngW'(131069);
         5'd8:    v = AngW'(65536);
         5'd9:    v = AngW'(32768);
         5'd10:   v = AngW'(16384);
         5'd11:   v = AngW'(8192);
         5'd12:   v = AngW'(4096);
         5'd13:   v = AngW'(2048);
         5'd14:   v = AngW'(1024);
         5'd15:   v = AngW'(512);
         5'd16:   v = AngW'(256);
         5'd17:   v = AngW'(128);
         5'd18:   v = AngW'(64);
         5'd19:   v = AngW'(32);
         5'd20:   v = AngW'(16);
         5'd21:   v = AngW'(8);
         5'd22:   v = AngW'(4);
         5'd23:   v = AngW'(2);
         default: v = '0;
      endcase
      return v;
   endfunction

   // optional negation, rounding to 2^-13 rad and clamp min(max(q, lo), hi)
   function automatic logic signed [AngOutW-1:0] q13_clamp(
      input logic signed [AngW-1:0]    ang,
      input logic                      negate,
      input logic signed [AngOutW-1:0] lo,
      input logic signed [AngOutW-1:0] hi
   );
      logic signed [AngW:0]          a;
      logic signed [AngW-OutShift:0] q;
      logic signed [AngW-OutShift:0] lo_e;
      logic signed [AngW-OutShift:0] hi_e;
      a    = negate ? -((AngW+1)'(ang)) : (AngW+1)'(ang);
      a    = a + RoundBias;
      q    = a[AngW:OutShift];
      lo_e = (AngW-OutShift+1)'(lo);
      hi_e = (AngW-OutShift+1)'(hi);
      if (q < lo_e) q = lo_e;
      if (q > hi_e) q = hi_e;
      return q[AngOutW-1:0];
   endfunction

endpackage

// ----- rtl/core/ptla_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptla_if: valid/ready channels of the look-at block
// request carries target and head points, response carries the angles
// ----------------------------------------------------------------------------
interface ptla_req_if import ptla_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] target_x;
   logic signed [CoordW-1:0] target_y;
   logic signed [CoordW-1:0] target_z;
   logic signed [CoordW-1:0] head_x;
   logic signed [CoordW-1:0] head_y;
   logic signed [CoordW-1:0] head_z;

   modport source (
      output valid, target_x, target_y, target_z, head_x, head_y, head_z,
      input  ready
   );
   modport sink (
      input  valid, target_x, target_y, target_z, head_x, head_y, head_z,
      output ready
   );
endinterface

interface ptla_rsp_if import ptla_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [AngOutW-1:0] pan_angle;
   logic signed [AngOutW-1:0] tilt_angle;
   logic                      target_replaced;

   modport source (
      output valid, pan_angle, tilt_angle, target_replaced,
      input  ready
   );
   modport sink (
      input  valid, pan_angle, tilt_angle, target_replaced,
      output ready
   );
endinterface

// ----- rtl/core/pan_tilt_look_at_deadband.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_look_at_deadband: look-at pan/tilt with a held-target deadband
// one multiplier, one square-root step and one cordic stage under a sequencer
// ----------------------------------------------------------------------------
// One request transaction is taken at a time; req ready is high only while the
// sequencer is idle. A transaction runs through the squared-distance check on
// the shared 25x25 multiplier, the offset, the squared hypot, a bit-serial
// square root, and two cordic vectoring passes of CORDIC_STEPS iterations each,
// each pass after its own load state, then a done state that rounds, clamps
// and loads the response register; the sequencer then returns to idle before
// the next request is taken. The response register frees the sequencer once it
// is loaded, so a response waiting on rsp ready holds off only a second finished
// transaction. CSR writes are expected only while no transaction is in flight.
// ----------------------------------------------------------------------------
module pan_tilt_look_at_deadband import ptla_pkg::*; #(
   parameter int CORDIC_STEPS = CordicStepsDef
) (
   input  logic                clock,
   input  logic                reset,
   ptla_req_if.sink            req_chan,
   ptla_rsp_if.source          rsp_chan,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // sequencer states
   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_DIST      = 10'b00_0000_0010,
      S_DIFF      = 10'b00_0000_0100,
      S_HYP       = 10'b00_0000_1000,
      S_SQRT      = 10'b00_0001_0000,
      S_PAN_INIT  = 10'b00_0010_0000,
      S_PAN       = 10'b00_0100_0000,
      S_TILT_INIT = 10'b00_1000_0000,
      S_TILT      = 10'b01_0000_0000,
      S_DONE      = 10'b10_0000_0000
   } state_type;

   // last step of each counted phase
   localparam logic [CntW-1:0] DistLast  = CntW'(4);
   localparam logic [CntW-1:0] HypLast   = CntW'(2);
   localparam logic [CntW-1:0] SqrtLast  = CntW'(SqRootW - 1);
   localparam logic [CntW-1:0] CordLast  = CntW'(CORDIC_STEPS - 1);

   // control state
   state_type                 state_ff, state_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic                      replace_ff, replace_in;
   logic                      zero_ff, zero_in;

   // held target (architectural state, cleared by reset)
   logic signed [CoordW-1:0]  held_ff [3];
   logic signed [CoordW-1:0]  held_in [3];

   // captured request
   logic signed [CoordW-1:0]  tgt_ff  [3];
   logic signed [CoordW-1:0]  tgt_in  [3];
   logic signed [CoordW-1:0]  head_ff [3];
   logic signed [CoordW-1:0]  head_in [3];

   // multiplier and accumulator
   logic signed [DiffW-1:0]   mul_op;
   logic signed [ProdW-1:0]   mul_prod_ff, mul_prod_in;
   logic [AccW-1:0]           prod_u;
   logic [AccW-1:0]           acc_ff, acc_in;
   logic signed [DiffW-1:0]   e_dist [3];
   logic signed [DiffW-1:0]   d_ff [3];
   logic signed [DiffW-1:0]   d_in [3];
   logic                      held_zero;

   // square root
   logic [SqInW-1:0]          sq_n_ff, sq_n_in;
   logic [SqRemW-1:0]         sq_rem_ff, sq_rem_in;
   logic [SqRootW-1:0]        sq_root_ff, sq_root_in;
   logic [SqRemW-1:0]         sq_sh;
   logic [SqRemW-1:0]         sq_trial;

   // cordic
   logic signed [CordW-1:0]   cx_ff, cx_in;
   logic signed [CordW-1:0]   cy_ff, cy_in;
   logic signed [AngW-1:0]    cz_ff, cz_in;
   logic signed [CordW-1:0]   vx, vy;
   logic signed [CordW-1:0]   xs, ys;
   logic signed [AngW-1:0]    cz_final;

   // angle results
   logic signed [AngOutW-1:0] pan_ff, pan_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [AngOutW-1:0] rsp_pan_ff, rsp_pan_in;
   logic signed [AngOutW-1:0] rsp_tilt_ff, rsp_tilt_in;
   logic                      rsp_repl_ff, rsp_repl_in;

   // csr registers
   logic [ThrW-1:0]           deadband_ff;
   logic signed [AngOutW-1:0] pan_min_ff, pan_max_ff, tilt_min_ff, tilt_max_ff;

   // ports
   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.pan_angle       = rsp_pan_ff;
   assign rsp_chan.tilt_angle      = rsp_tilt_ff;
   assign rsp_chan.target_replaced = rsp_repl_ff;

   // shared datapath terms
   assign held_zero = (held_ff[0] == '0) && (held_ff[1] == '0) && (held_ff[2] == '0);
   assign prod_u    = AccW'($unsigned(mul_prod_ff));
   assign sq_sh     = {sq_rem_ff[SqRemW-3:0], sq_n_ff[SqInW-1 -: 2]};
   assign sq_trial  = {2'b00, sq_root_ff, 2'b01};
   assign xs        = cx_ff >>> cnt_ff;
   assign ys        = cy_ff >>> cnt_ff;
   // a zero vector has angle zero, rounded and clamped like any other
   assign cz_final  = zero_ff ? '0 : cz_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e_dist[k] = DiffW'(tgt_ff[k]) - DiffW'(held_ff[k]);
      end

      // operand of the shared squarer, chosen by phase and step
      mul_op = '0;
      if (state_ff == S_DIST) begin
         if (cnt_ff == CntW'(0))      mul_op = e_dist[0];
         else if (cnt_ff == CntW'(1)) mul_op = e_dist[1];
         else if (cnt_ff == CntW'(2)) mul_op = e_dist[2];
         else                         mul_op = DiffW'(deadband_ff);
      end else if (state_ff == S_HYP) begin
         if (cnt_ff == CntW'(0)) mul_op = d_ff[0];
         else                    mul_op = d_ff[1];
      end
      mul_prod_in = ProdW'(mul_op) * ProdW'(mul_op);

      // vector loaded at the start of a cordic pass
      if (state_ff == S_PAN_INIT) begin
         vx = CordW'(d_ff[0]) <<< PreShift;
         vy = CordW'(d_ff[1]) <<< PreShift;
      end else begin
         vx = $signed(CordW'(sq_root_ff) << HypShift);
         vy = CordW'(d_ff[2]) <<< PreShift;
      end
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      replace_in   = replace_ff;
      zero_in      = zero_ff;
      acc_in       = acc_ff;
      sq_n_in      = sq_n_ff;
      sq_rem_in    = sq_rem_ff;
      sq_root_in   = sq_root_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      pan_in       = pan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pan_in   = rsp_pan_ff;
      rsp_tilt_in  = rsp_tilt_ff;
      rsp_repl_in  = rsp_repl_ff;
      for (int k = 0; k < 3; k++) begin
         held_in[k] = held_ff[k];
         tgt_in[k]  = tgt_ff[k];
         head_in[k] = head_ff[k];
         d_in[k]    = d_ff[k];
      end

      unique case (state_ff) inside
         S_IDLE: begin
            if (req_chan.valid) begin
               tgt_in[0]  = req_chan.target_x;
               tgt_in[1]  = req_chan.target_y;
               tgt_in[2]  = req_chan.target_z;
               head_in[0] = req_chan.head_x;
               head_in[1] = req_chan.head_y;
               head_in[2] = req_chan.head_z;
               cnt_in     = '0;
               state_in   = S_DIST;
            end
         end
         S_DIST: begin
            // squares of the move are registered and land behind their operands
            if (cnt_ff == CntW'(1)) begin
               acc_in = prod_u;
            end else if (cnt_ff == CntW'(2) || cnt_ff == CntW'(3)) begin
               acc_in = acc_ff + prod_u;
            end
            if (cnt_ff == DistLast) begin
               // product now holds threshold squared
               replace_in = held_zero || (acc_ff > prod_u);
               if (replace_in) begin
                  for (int k = 0; k < 3; k++) held_in[k] = tgt_ff[k];
               end
               state_in = S_DIFF;
            end else begin
               cnt_in = cnt_ff + CntW'(1);
            end
         end
         S_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               d_in[k] = DiffW'(held_ff[k]) - DiffW'(head_ff[k]);
            end
            cnt_in   = '0;
            state_in = S_HYP;
         end
         S_HYP: begin
            if (cnt_ff == CntW'(1)) acc_in = prod_u;
            else if (cnt_ff == HypLast) acc_in = acc_ff + prod_u;
            if (cnt_ff == HypLast) begin
               sq_n_in    = {acc_in[SqInW-SqShift-1:0], {SqShift{1'b0}}};
               sq_rem_in  = '0;
               sq_root_in = '0;
               cnt_in     = '0;
               state_in   = S_SQRT;
            end else begin
               cnt_in = cnt_ff + CntW'(1);
            end
         end
         S_SQRT: begin
            // restoring square root, one root bit per step
            sq_n_in = sq_n_ff << 2;
            if (sq_sh >= sq_trial) begin
               sq_rem_in  = sq_sh - sq_trial;
               sq_root_in = {sq_root_ff[SqRootW-2:0], 1'b1};
            end else begin
               sq_rem_in  = sq_sh;
               sq_root_in = {sq_root_ff[SqRootW-2:0], 1'b0};
            end
            if (cnt_ff == SqrtLast) state_in = S_PAN_INIT;
            cnt_in = cnt_ff + CntW'(1);
         end
         S_PAN_INIT, S_TILT_INIT: begin
            if (state_ff == S_TILT_INIT) begin
               pan_in = q13_clamp(cz_final, 1'b0, pan_min_ff, pan_max_ff);
            end
            // left half-plane: fold by pi first
            zero_in = (vx == '0) && (vy == '0);
            if (vx < 0) begin
               cx_in = -vx;
               cy_in = -vy;
               cz_in = (vy >= 0) ? PiFine : -PiFine;
            end else begin
               cx_in = vx;
               cy_in = vy;
               cz_in = '0;
            end
            cnt_in   = '0;
            state_in = (state_ff == S_PAN_INIT) ? S_PAN : S_TILT;
         end
         S_PAN, S_TILT: begin
            if (cy_ff >= 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_fine(cnt_ff);
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_fine(cnt_ff);
            end
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CordLast) begin
               state_in = (state_ff == S_PAN) ? S_TILT_INIT : S_DONE;
            end
         end
         S_DONE: begin
            // wait for the response register to be free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pan_in   = pan_ff;
               rsp_tilt_in  = q13_clamp(cz_final, 1'b1, tilt_min_ff, tilt_max_ff);
               rsp_repl_in  = replace_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state, held target and csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) held_ff[k] <= '0;
         deadband_ff  <= DeadbandRst;
         pan_min_ff   <= PanMinRst;
         pan_max_ff   <= PanMaxRst;
         tilt_min_ff  <= TiltMinRst;
         tilt_max_ff  <= TiltMaxRst;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 3; k++) held_ff[k] <= held_in[k];
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEADBAND: deadband_ff <= csr_wdata[ThrW-1:0];
               CSR_PAN_MIN:  pan_min_ff  <= csr_wdata[AngOutW-1:0];
               CSR_PAN_MAX:  pan_max_ff  <= csr_wdata[AngOutW-1:0];
               CSR_TILT_MIN: tilt_min_ff <= csr_wdata[AngOutW-1:0];
               CSR_TILT_MAX: tilt_max_ff <= csr_wdata[AngOutW-1:0];
               default: begin
                  // unmapped index: write dropped
               end
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      replace_ff  <= replace_in;
      zero_ff     <= zero_in;
      mul_prod_ff <= mul_prod_in;
      acc_ff      <= acc_in;
      sq_n_ff     <= sq_n_in;
      sq_rem_ff   <= sq_rem_in;
      sq_root_ff  <= sq_root_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      pan_ff      <= pan_in;
      rsp_pan_ff  <= rsp_pan_in;
      rsp_tilt_ff <= rsp_tilt_in;
      rsp_repl_ff <= rsp_repl_in;
      for (int k = 0; k < 3; k++) begin
         tgt_ff[k]  <= tgt_in[k];
         head_ff[k] <= head_in[k];
         d_ff[k]    <= d_in[k];
      end
   end

`ifndef ASSERT_OFF
   // held target either took the new point or kept its old value
   a_held_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIFF) |->
         (replace_ff ? (held_ff[0] == tgt_ff[0] && held_ff[1] == tgt_ff[1] &&
                        held_ff[2] == tgt_ff[2])
                     : (held_ff[0] == $past(held_ff[0]) &&
                        held_ff[1] == $past(held_ff[1]) &&
                        held_ff[2] == $past(held_ff[2]))))
      else $error("held target update inconsistent with replace decision");

   // square root is the floor root of the scaled hypot radicand
   a_sqrt_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAN_INIT) |->
         ((66'(sq_root_ff) * 66'(sq_root_ff) <=
           66'({acc_ff[SqInW-SqShift-1:0], {SqShift{1'b0}}})) &&
          ((66'(sq_root_ff) + 66'(1)) * (66'(sq_root_ff) + 66'(1)) >
           66'({acc_ff[SqInW-SqShift-1:0], {SqShift{1'b0}}}))))
      else $error("square root result out of range");

   // delivered pan respects its limits
   a_pan_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((pan_min_ff > pan_max_ff) ? (rsp_pan_ff == pan_max_ff)
                                    : (rsp_pan_ff >= pan_min_ff &&
                                       rsp_pan_ff <= pan_max_ff)))
      else $error("pan response outside configured limits");
`endif

endmodule
